@@ rtl/mctb_pkg.sv @@
// Package for the timer bank: field widths, request and result codes,
// controller/datapath command and status types. No dependencies.
package mctb_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int CNT_W           = 5;

	localparam int REQ_W  = 3;
	localparam int SLOT_W = 4;
	localparam int TICK_W = 32;
	localparam int KIND_W = 2;

	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FREE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_START = 3'd3;
	localparam logic [REQ_W-1:0] REQ_STOP  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SCAN  = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic idle;       // input channel open
		logic load_req;   // capture the incoming word
		logic op_exec;    // apply tick/free/start/stop and acknowledge
		logic alloc_take; // claim slot at the slot pointer
		logic alloc_fail; // answer a failed allocation
		logic adv;        // advance the slot pointer
		logic scan_hit;   // retire the expired slot at the pointer
		logic scan_end;   // flush the held expiry or answer nothing found
	} mctb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             new_valid;
		logic [REQ_W-1:0] new_req;
		logic             slot_free;
		logic             idx_last;
		logic             hit;
		logic             pend_valid;
		logic             out_free;
		logic             cnt_last;
	} mctb_sts_t;

endpackage

@@ rtl/mctb_if.sv @@
// Request and result channel interfaces of the timer bank.
// Depends on mctb_pkg for field widths.
interface mctb_req_if import mctb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [SLOT_W-1:0] slot_index;
	logic [TICK_W-1:0] target_ticks;
	logic              periodic;

	modport source (output valid, req_type, slot_index, target_ticks, periodic, input ready);
	modport sink (input valid, req_type, slot_index, target_ticks, periodic, output ready);
endinterface

interface mctb_res_if import mctb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [SLOT_W-1:0] result_slot;
	logic              ok;
	logic              last;

	modport source (output valid, result_kind, result_slot, ok, last, input ready);
	modport sink (input valid, result_kind, result_slot, ok, last, output ready);
endinterface

@@ rtl/multi_channel_timer_bank_unit.sv @@
// Top level of the timer bank: wires the controller to the datapath.
// Depends on mctb_pkg, mctb_if, mctb_ctrl and mctb_dp.
//
// Usage
//   req: request words (req_type, slot_index, target_ticks, periodic) on a
//     valid/ready channel. A word is taken only while the bank is idle, so
//     one request is worked at a time.
//   res: result words (result_kind, result_slot, ok, last). Every request
//     gives one word except a scan, which gives one word per expired slot
//     in slot order (at most MAX_RESULTS), or one "nothing found" word;
//     last marks the final word of the request.
//   Sequence: tick, free, start, stop and unknown codes are acknowledged
//     from the execute state once the output register is free. Allocate
//     walks the allocation flags one slot a cycle until it finds a free slot
//     or reaches the last one. A scan passes a read-prime state, then reads
//     the start-time and target RAMs one slot a cycle, pausing on an expiry while
//     a held expiry still waits in the output register.
//   Stall: a word waiting in the output register holds the bank where its
//     next word would be written; the next request is taken as soon as the
//     last word of the current one is in the output register, even while
//     that word still waits.
//   Reset: clears the tick counter and all slot flags; the RAMs are left
//     as they are and their contents are never used for a slot that has not been started.
module multi_channel_timer_bank_unit import mctb_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mctb_req_if.sink   req,
	mctb_res_if.source res
);

	mctb_cmd_t cmd;
	mctb_sts_t sts;

	// sequencing
	mctb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// storage, compare and output staging
	mctb_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

@@ rtl/mctb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mctb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ rtl/mctb_ctrl.sv @@
// Sequencing state machine of the timer bank.
// Depends on mctb_pkg; drives mctb_dp through command and status structs.
module mctb_ctrl import mctb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mctb_sts_t sts,
	output mctb_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EXEC     = 3'd1;
	localparam logic [2:0] ST_ALLOC    = 3'd2;
	localparam logic [2:0] ST_SCAN_RD  = 3'd3;
	localparam logic [2:0] ST_SCAN_CMP = 3'd4;
	localparam logic [2:0] ST_SCAN_END = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.new_valid) begin
					cmd.load_req = 1'b1;
					case (sts.new_req)
						REQ_ALLOC: state_d = ST_ALLOC;
						REQ_SCAN:  state_d = ST_SCAN_RD;
						default:   state_d = ST_EXEC;
					endcase
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					cmd.op_exec = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_ALLOC: begin
				if (sts.slot_free) begin
					if (sts.out_free) begin
						cmd.alloc_take = 1'b1;
						state_d        = ST_IDLE;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.alloc_fail = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (sts.hit) begin
					// a held expiry must leave before the next one is taken
					if (!sts.pend_valid || sts.out_free) begin
						cmd.scan_hit = 1'b1;
						if (sts.idx_last || sts.cnt_last) begin
							state_d = ST_SCAN_END;
						end else begin
							cmd.adv = 1'b1;
						end
					end
				end else if (sts.idx_last) begin
					state_d = ST_SCAN_END;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_SCAN_END: begin
				if (sts.out_free) begin
					cmd.scan_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.pend_valid)
		else $error("held expiry left over after a scan");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_END && sts.out_free) |=> (state_q == ST_IDLE))
		else $error("scan did not close when the output was free");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= ST_SCAN_END)
		else $error("controller state out of range");

endmodule

@@ rtl/mctb_dp.sv @@
// Datapath of the timer bank: tick counter, slot flags, slot pointer,
// start-time and target RAMs, held expiry and output register.
// Depends on mctb_pkg, mctb_if and mctb_ram.
module mctb_dp import mctb_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mctb_req_if.sink   req,
	mctb_res_if.source res,
	input  mctb_cmd_t  cmd,
	output mctb_sts_t  sts
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic [TICK_W-1:0]      now_q;
	logic [TIMER_SLOTS-1:0] alloc_q;
	logic [TIMER_SLOTS-1:0] run_q;
	logic [TIMER_SLOTS-1:0] per_q;

	logic [REQ_W-1:0]  req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TICK_W-1:0] tgt_q;
	logic              per_in_q;

	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_ok_q;
	logic              out_last_q;

	logic [IDX_W-1:0]  slot_ix;
	logic              in_range;
	logic [IDX_W-1:0]  rd_addr;
	logic [TICK_W-1:0] start_rd;
	logic [TICK_W-1:0] tgt_rd;
	logic [TICK_W-1:0] elapsed;
	logic              hit;
	logic              out_free;
	logic              out_load;
	logic              start_we;
	logic              reload_we;

	assign slot_ix  = IDX_W'(slot_q);
	assign in_range = 32'(slot_q) < 32'(TIMER_SLOTS);
	assign rd_addr  = cmd.adv ? idx_q + 1'b1 : idx_q;
	assign elapsed  = now_q - start_rd;
	assign hit      = run_q[idx_q] && (elapsed >= tgt_rd);
	assign out_free = !out_valid_q || res.ready;
	assign out_load = cmd.op_exec || cmd.alloc_take || cmd.alloc_fail ||
		(cmd.scan_hit && pend_valid_q) || cmd.scan_end;

	assign start_we  = cmd.op_exec && (req_q == REQ_START) && in_range && alloc_q[slot_ix];
	assign reload_we = cmd.scan_hit && per_q[idx_q];

	assign sts.new_valid  = req.valid;
	assign sts.new_req    = req.req_type;
	assign sts.slot_free  = !alloc_q[idx_q];
	assign sts.idx_last   = idx_q == IDX_W'(TIMER_SLOTS - 1);
	assign sts.hit        = hit;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;
	assign sts.cnt_last   = cnt_q == CNT_W'(MAX_RESULTS - 1);

	assign req.ready       = cmd.idle;
	assign res.valid       = out_valid_q;
	assign res.result_kind = out_kind_q;
	assign res.result_slot = out_slot_q;
	assign res.ok          = out_ok_q;
	assign res.last        = out_last_q;

	// start time: written by start, rewritten by a periodic reload
	mctb_ram #(.WIDTH(TICK_W), .DEPTH(TIMER_SLOTS)) u_start_ram (
		.clk     (clk),
		.we      (start_we || reload_we),
		.waddr   (start_we ? slot_ix : idx_q),
		.wdata   (now_q),
		.raddr   (rd_addr),
		.rdata_q (start_rd)
	);

	mctb_ram #(.WIDTH(TICK_W), .DEPTH(TIMER_SLOTS)) u_tgt_ram (
		.clk     (clk),
		.we      (start_we),
		.waddr   (slot_ix),
		.wdata   (tgt_q),
		.raddr   (rd_addr),
		.rdata_q (tgt_rd)
	);

	// captured request word
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q    <= req.req_type;
			slot_q   <= req.slot_index;
			tgt_q    <= req.target_ticks;
			per_in_q <= req.periodic;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			alloc_q      <= '0;
			run_q        <= '0;
			per_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.op_exec) begin
				case (req_q)
					REQ_TICK: begin
						now_q <= now_q + 1'b1;
					end
					REQ_FREE: begin
						if (in_range) begin
							alloc_q[slot_ix] <= 1'b0;
							run_q[slot_ix]   <= 1'b0;
						end
					end
					REQ_START: begin
						if (start_we) begin
							run_q[slot_ix] <= 1'b1;
							per_q[slot_ix] <= per_in_q;
						end
					end
					REQ_STOP: begin
						if (in_range) begin
							run_q[slot_ix] <= 1'b0;
							per_q[slot_ix] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.alloc_take) begin
				alloc_q[idx_q] <= 1'b1;
				run_q[idx_q]   <= 1'b0;
				per_q[idx_q]   <= 1'b0;
			end
			// one-shot slots stop on expiry
			if (cmd.scan_hit && !per_q[idx_q]) begin
				run_q[idx_q] <= 1'b0;
			end

			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.adv) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.load_req) begin
				cnt_q <= '0;
			end else if (cmd.scan_hit) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (cmd.load_req || cmd.scan_end) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.scan_hit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_hit) begin
			pend_slot_q <= SLOT_W'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_exec) begin
			out_kind_q <= KIND_ACK;
			out_slot_q <= '0;
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b1;
		end else if (cmd.alloc_take) begin
			out_kind_q <= KIND_ALLOC;
			out_slot_q <= SLOT_W'(idx_q);
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b1;
		end else if (cmd.alloc_fail) begin
			out_kind_q <= KIND_ALLOC;
			out_slot_q <= '0;
			out_ok_q   <= 1'b0;
			out_last_q <= 1'b1;
		end else if (cmd.scan_hit && pend_valid_q) begin
			out_kind_q <= KIND_EXPIRY;
			out_slot_q <= pend_slot_q;
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b0;
		end else if (cmd.scan_end) begin
			out_kind_q <= pend_valid_q ? KIND_EXPIRY : KIND_NONE;
			out_slot_q <= pend_valid_q ? pend_slot_q : '0;
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	a_run_needs_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~alloc_q) == '0)
		else $error("running slot is not allocated");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("expiry count beyond limit");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for multi_channel_timer_bank_unit: directed and random requests
// checked word by word against a shadow of the timer bank.
// Depends on mctb_pkg, mctb_if and the timer bank RTL.
module tb import mctb_pkg::*; ;

	localparam int SLOTS = TIMER_SLOTS_DEF;
	localparam int CLK_HALF = 5;
	localparam int RANDOM_ITEMS = 180;
	localparam int LONG_HOLD = 300;
	localparam int TIMEOUT_NS = 4_000_000;

	// Request codes the block does not know; they are only acknowledged.
	localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic              ok;
		logic              last;
	} result_word_t;

	// Shadow of the timer bank: tracks tick count and slot flags, and keeps
	// the result words still owed by the block in the order they must come.
	class timer_bank_shadow;
		logic [TICK_W-1:0] tick_count;
		bit                in_use [SLOTS];
		bit                armed [SLOTS];
		bit                reload [SLOTS];
		logic [TICK_W-1:0] armed_at [SLOTS];
		logic [TICK_W-1:0] duration [SLOTS];
		result_word_t      owed_words [$];
		int                errors;

		function new();
			tick_count = '0;
			errors = 0;
			foreach (in_use[i]) begin
				in_use[i] = 1'b0;
				armed[i] = 1'b0;
				reload[i] = 1'b0;
				armed_at[i] = '0;
				duration[i] = '0;
			end
		endfunction

		function void queue_word(logic [KIND_W-1:0] kind, int slot, logic ok, logic last);
			result_word_t w;
			w.kind = kind;
			w.slot = slot[SLOT_W-1:0];
			w.ok = ok;
			w.last = last;
			owed_words.push_back(w);
		endfunction

		function int outstanding();
			return owed_words.size();
		endfunction

		function logic [SLOT_W-1:0] pick_busy_slot();
			int busy [$];
			foreach (in_use[i])
				if (in_use[i])
					busy.push_back(i);
			if (busy.size() == 0)
				return SLOT_W'($urandom_range(0, SLOTS - 1));
			return SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]);
		endfunction

		function void note_request(logic [REQ_W-1:0] rt, logic [SLOT_W-1:0] si,
				logic [TICK_W-1:0] tt, logic pe);
			logic [TICK_W-1:0] elapsed;
			bit                in_range;
			bit                found;
			int                hits;
			in_range = int'(si) < SLOTS;
			found = 1'b0;
			hits = 0;
			case (rt)
				REQ_TICK: begin
					tick_count = tick_count + 1'b1;
				end
				REQ_ALLOC: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!found && !in_use[i]) begin
							found = 1'b1;
							in_use[i] = 1'b1;
							armed[i] = 1'b0;
							reload[i] = 1'b0;
							queue_word(KIND_ALLOC, i, 1'b1, 1'b1);
						end
					end
					if (!found)
						queue_word(KIND_ALLOC, 0, 1'b0, 1'b1);
				end
				REQ_FREE: begin
					if (in_range) begin
						in_use[si] = 1'b0;
						armed[si] = 1'b0;
					end
				end
				REQ_START: begin
					if (in_range && in_use[si]) begin
						armed_at[si] = tick_count;
						duration[si] = tt;
						armed[si] = 1'b1;
						reload[si] = pe;
					end
				end
				REQ_STOP: begin
					if (in_range) begin
						armed[si] = 1'b0;
						reload[si] = 1'b0;
					end
				end
				REQ_SCAN: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (hits < MAX_RESULTS && armed[i]) begin
							elapsed = tick_count - armed_at[i];
							if (elapsed >= duration[i]) begin
								if (reload[i])
									armed_at[i] = tick_count;
								else
									armed[i] = 1'b0;
								queue_word(KIND_EXPIRY, i, 1'b1, 1'b0);
								hits++;
							end
						end
					end
					if (hits == 0)
						queue_word(KIND_NONE, 0, 1'b1, 1'b1);
					else
						owed_words[owed_words.size() - 1].last = 1'b1;
				end
				default: ;
			endcase
			if (rt != REQ_ALLOC && rt != REQ_SCAN)
				queue_word(KIND_ACK, 0, 1'b1, 1'b1);
		endfunction

		function void flag(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_word(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
				logic ok, logic last);
			result_word_t want;
			if (owed_words.size() == 0) begin
				$display("%0t: unexpected result word: expected none, got kind %0d slot %0d ok %0d last %0d",
					$time, kind, slot, ok, last);
				errors++;
				return;
			end
			want = owed_words.pop_front();
			if (kind !== want.kind)
				flag("result_kind", want.kind, kind);
			if (slot !== want.slot)
				flag("result_slot", want.slot, slot);
			if (ok !== want.ok)
				flag("ok", want.ok, ok);
			if (last !== want.last)
				flag("last", want.last, last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   hold_request;

	mctb_req_if req_ch ();
	mctb_res_if res_ch ();

	timer_bank_shadow shadow = new();

	multi_channel_timer_bank_unit #(
		.TIMER_SLOTS(SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the bank hangs or drops words.
	initial begin
		#TIMEOUT_NS;
		$display("tb: failure");
		$finish;
	end

	// Watch both channels at the rising edge: feed accepted requests to the
	// shadow first, then compare any result word taken at the same edge.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			shadow.note_request(req_ch.req_type, req_ch.slot_index,
				req_ch.target_ticks, req_ch.periodic);
		if (arst_n && res_ch.valid && res_ch.ready)
			shadow.check_word(res_ch.result_kind, res_ch.result_slot,
				res_ch.ok, res_ch.last);
	end

	// Result side: switch among four stall patterns chosen at random, and honor
	// one long hold-off when the request side asks for it. Counting happens
	// here so the sender keeps pushing words while the bank backs up.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int cyc;
		bit hold_taken;
		res_ch.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		cyc = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = 50;
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_ch.ready <= 1'b1;                       // no stalls at all
					1: res_ch.ready <= $urandom_range(0, 1);       // coin flip
					2: res_ch.ready <= (cyc % 4) != 3;             // one stall in four
					default: res_ch.ready <= $urandom_range(0, 3) == 0; // mostly stalled
				endcase
			end
		end
	end

	// Drive one request word from the falling edge and hold it until taken.
	task automatic send_word(input logic [REQ_W-1:0] rt, input logic [SLOT_W-1:0] si,
			input logic [TICK_W-1:0] tt, input logic pe);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.slot_index <= si;
		req_ch.target_ticks <= tt;
		req_ch.periodic <= pe;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid for a number of cycles.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Drop valid and hold off until every owed result word has come back.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [REQ_W-1:0]  rt;
		logic [SLOT_W-1:0] si;
		logic [TICK_W-1:0] tt;
		logic              pe;
		int                roll;
		int                burst_left;

		arst_n = 1'b0;
		hold_request = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.slot_index = '0;
		req_ch.target_ticks = '0;
		req_ch.periodic = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed part. Scan an empty bank, send both unknown codes, then
		// start and free slots that were never allocated.
		send_word(REQ_SCAN, '0, '0, 1'b0);
		send_word(REQ_RSVD6, '0, '0, 1'b0);
		send_word(REQ_RSVD7, '1, '1, 1'b1);
		send_word(REQ_START, 4'd3, 32'd5, 1'b1);
		send_word(REQ_FREE, 4'd12, '0, 1'b0);
		// Fill the bank, then ask once more so allocation fails.
		for (int i = 0; i < SLOTS; i++)
			send_word(REQ_ALLOC, SLOT_W'(i), 32'hA5A5_5A5A, i[0]);
		send_word(REQ_ALLOC, '0, '0, 1'b0);
		// Zero periodic target expires on every scan; all-ones never does.
		send_word(REQ_START, 4'd0, 32'd0, 1'b1);
		send_word(REQ_START, 4'd15, '1, 1'b0);
		send_word(REQ_SCAN, '0, '0, 1'b0);
		drain();

		// Random part: bursts of words with gaps between them.
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 60)
				hold_request = 1'b1;
			if (n == 120)
				drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 4) == 0 ? 30 : $urandom_range(1, 12);
				idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
			end
			burst_left--;

			roll = $urandom_range(0, 99);
			rt = roll < 34 ? REQ_TICK :
				roll < 44 ? REQ_ALLOC :
				roll < 50 ? REQ_FREE :
				roll < 70 ? REQ_START :
				roll < 76 ? REQ_STOP :
				roll < 96 ? REQ_SCAN :
				roll < 98 ? REQ_RSVD6 : REQ_RSVD7;
			si = SLOT_W'($urandom_range(0, SLOTS - 1));
			tt = $urandom();
			pe = $urandom_range(0, 1);
			// Aim most starts at live slots with short targets so scans hit.
			if (rt == REQ_START) begin
				if ($urandom_range(0, 3) != 0)
					si = shadow.pick_busy_slot();
				if ($urandom_range(0, 4) != 0)
					tt = $urandom_range(0, 6);
			end else if ((rt == REQ_FREE || rt == REQ_STOP) && $urandom_range(0, 1) == 1) begin
				si = shadow.pick_busy_slot();
			end
			send_word(rt, si, tt, pe);
		end

		drain();
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (shadow.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
